// ===== rtl/bdm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the background-debug serial master.
// Used by every module of the block; depends on nothing.
package bdm_pkg;

	// Serial frame: one attention bit followed by the data bits
	localparam int FRAME_BITS = 17;
	localparam int IDX_W      = ($clog2(FRAME_BITS) > 5) ? $clog2(FRAME_BITS) : 5;
	localparam int WORD_W     = 16;
	localparam int LONG_BIT   = 7;

	// Command queue between front and back
	localparam int Q_DEPTH  = 2;
	localparam int QPTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int QCOUNT_W = $clog2(Q_DEPTH + 1);

	localparam logic [WORD_W-1:0] POLL_LIMIT_RESET = 16'd1024;

	// Input command codes
	typedef enum logic [1:0] {
		CMD_WRITE = 2'd0,
		CMD_READ  = 2'd1,
		CMD_TICK  = 2'd2
	} cmd_t;

	// Classified item kinds carried through the queue
	typedef enum logic [1:0] {
		KIND_WRITE,
		KIND_READ,
		KIND_TICK
	} kind_t;

	// Sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE      = 4'd0,
		PH_OPCODE    = 4'd1,
		PH_ADDR_HIGH = 4'd2,
		PH_ADDR_LOW  = 4'd3,
		PH_DATA_HIGH = 4'd4,
		PH_DATA_LOW  = 4'd5,
		PH_POLL_HIGH = 4'd6,
		PH_POLL_LOW  = 4'd7
	} phase_t;

	typedef struct packed {
		kind_t             kind;
		logic [WORD_W-1:0] opcode;
		logic [WORD_W-1:0] addr_high;
		logic [WORD_W-1:0] addr_low;
		logic [WORD_W-1:0] data_high;
		logic [WORD_W-1:0] data_low;
		logic              dso;
	} item_t;

	// Queue handshake seen by the front
	typedef struct packed {
		logic  push;
		item_t item;
	} push_t;

	// Queue handshake seen by the back
	typedef struct packed {
		logic  valid;
		item_t item;
	} head_t;

endpackage

// ===== rtl/bdm_front.sv =====
`timescale 1ns / 1ps
// Front end: takes input transactions, classifies the command code and
// pushes legal items into the command queue. Depends on bdm_pkg.
module bdm_front import bdm_pkg::*; (
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [WORD_W-1:0] bdm_opcode,
	input  logic [WORD_W-1:0] addr_high,
	input  logic [WORD_W-1:0] addr_low,
	input  logic [WORD_W-1:0] data_high,
	input  logic [WORD_W-1:0] data_low,
	input  logic              dso_bit,
	input  logic              q_full,
	output push_t             q_push
);

	logic  accept;
	logic  legal;
	kind_t kind;

	// Stall only while the queue has no room
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;

	// Classify the command; drop unknown codes
	always_comb begin
		legal = 1'b1;
		kind  = KIND_TICK;
		case (command)
			CMD_WRITE: kind = KIND_WRITE;
			CMD_READ:  kind = KIND_READ;
			CMD_TICK:  kind = KIND_TICK;
			default:   legal = 1'b0;
		endcase
	end

	always_comb begin
		q_push.push           = accept && legal;
		q_push.item.kind      = kind;
		q_push.item.opcode    = bdm_opcode;
		q_push.item.addr_high = addr_high;
		q_push.item.addr_low  = addr_low;
		q_push.item.data_high = data_high;
		q_push.item.data_low  = data_low;
		q_push.item.dso       = dso_bit;
	end

endmodule

// ===== rtl/bdm_queue.sv =====
`timescale 1ns / 1ps
// Short command queue that decouples the front end from the sequencer.
// Depends on bdm_pkg.
module bdm_queue import bdm_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  push_t q_push,
	output logic  q_full,
	input  logic  q_pop,
	output head_t q_head
);

	item_t               entries_q [Q_DEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q;
	logic [QPTR_W-1:0]   rd_ptr_q;
	logic [QCOUNT_W-1:0] count_q;
	logic                do_pop;

	assign q_full       = (count_q == QCOUNT_W'(Q_DEPTH));
	assign do_pop       = q_pop && (count_q != '0);
	assign q_head.valid = (count_q != '0);
	assign q_head.item  = entries_q[rd_ptr_q];

	// Store pushed entries
	always_ff @(posedge clk) begin
		if (q_push.push) begin
			entries_q[wr_ptr_q] <= q_push.item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push.push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_push.push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!q_push.push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== rtl/bdm_back.sv =====
`timescale 1ns / 1ps
// Back end: frame sequencer, poll limit register and output register.
// Consumes items from the command queue. Depends on bdm_pkg.
module bdm_back import bdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WORD_W-1:0] cfg_data,
	input  head_t             q_head,
	output logic              q_pop,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              dsi_bit,
	output logic              clock_pulse,
	output logic              frame_end,
	output logic              attention,
	output logic              command_done,
	output logic              timed_out,
	output logic [WORD_W-1:0] response_high,
	output logic [WORD_W-1:0] response_low
);

	// Sequencer state
	phase_t            phase_q, phase_d;
	logic [IDX_W-1:0]  bit_index_q, bit_index_d;
	logic [WORD_W-1:0] in_shift_q, in_shift_d;
	logic              attention_q, attention_d;
	logic              is_read_q, is_read_d;
	logic [WORD_W-1:0] high_result_q, high_result_d;
	logic [WORD_W-1:0] poll_count_q, poll_count_d;
	logic [WORD_W-1:0] poll_limit_q;

	// Held command words, written at issue
	logic [WORD_W-1:0] opcode_q, addr_high_q, addr_low_q, data_high_q, data_low_q;
	logic              load_words;

	// Output register
	logic              out_valid_q;
	logic              dsi_q, fend_q, att_q, done_q, tmo_q;
	logic [WORD_W-1:0] resp_high_q, resp_low_q;

	logic              out_free;
	logic              load_out;
	logic              dsi_d, fend_d, done_d, tmo_d;
	logic [WORD_W-1:0] resp_low_d;
	logic [WORD_W-1:0] cur_word;
	logic [IDX_W-1:0]  pos;
	logic [WORD_W-1:0] poll_inc;
	logic [WORD_W-1:0] limit;
	item_t             item;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = q_head.valid && out_free;
	assign item      = q_head.item;

	// Phase after the address frames
	function automatic phase_t after_address(input logic rd, input logic long_xfer);
		phase_t p;
		if (rd) begin
			p = long_xfer ? PH_POLL_HIGH : PH_POLL_LOW;
		end else begin
			p = long_xfer ? PH_DATA_HIGH : PH_DATA_LOW;
		end
		return p;
	endfunction

	// Word driven in the current phase
	always_comb begin
		case (phase_q)
			PH_OPCODE:    cur_word = opcode_q;
			PH_ADDR_HIGH: cur_word = addr_high_q;
			PH_ADDR_LOW:  cur_word = addr_low_q;
			PH_DATA_HIGH: cur_word = data_high_q;
			PH_DATA_LOW:  cur_word = data_low_q;
			default:      cur_word = '0;
		endcase
	end

	assign pos      = IDX_W'(FRAME_BITS - 1) - bit_index_q;
	assign poll_inc = poll_count_q + 1'b1;
	assign limit    = (poll_limit_q == '0) ? WORD_W'(1) : poll_limit_q;

	// Next state and result for the item at the head of the queue
	always_comb begin
		phase_d       = phase_q;
		bit_index_d   = bit_index_q;
		in_shift_d    = in_shift_q;
		attention_d   = attention_q;
		is_read_d     = is_read_q;
		high_result_d = high_result_q;
		poll_count_d  = poll_count_q;
		load_words    = 1'b0;
		load_out      = 1'b0;
		dsi_d         = 1'b0;
		fend_d        = 1'b0;
		done_d        = 1'b0;
		tmo_d         = 1'b0;
		resp_low_d    = '0;
		if (q_pop) begin
			case (item.kind)
				KIND_WRITE, KIND_READ: begin
					// Issue loads only while idle
					if (phase_q == PH_IDLE) begin
						load_words    = 1'b1;
						is_read_d     = (item.kind == KIND_READ);
						high_result_d = '0;
						poll_count_d  = '0;
						attention_d   = 1'b0;
						phase_d       = PH_OPCODE;
						bit_index_d   = '0;
					end
				end
				KIND_TICK: begin
					if (phase_q != PH_IDLE) begin
						load_out = 1'b1;
						// Attention bit first, then data MSB first
						if (bit_index_q == '0) begin
							attention_d = item.dso;
						end else begin
							if (pos < IDX_W'(WORD_W)) begin
								dsi_d = cur_word[pos[3:0]];
							end
							in_shift_d = {in_shift_q[WORD_W-2:0], item.dso};
						end
						if (bit_index_q != IDX_W'(FRAME_BITS - 1)) begin
							bit_index_d = bit_index_q + 1'b1;
						end else begin
							fend_d      = 1'b1;
							resp_low_d  = in_shift_d;
							bit_index_d = '0;
							case (phase_q)
								PH_OPCODE: begin
									if (addr_high_q != '0 || addr_low_q != '0) begin
										phase_d = PH_ADDR_HIGH;
									end else begin
										phase_d = after_address(is_read_q, opcode_q[LONG_BIT]);
									end
								end
								PH_ADDR_HIGH: phase_d = PH_ADDR_LOW;
								PH_ADDR_LOW:  phase_d = after_address(is_read_q, opcode_q[LONG_BIT]);
								PH_DATA_HIGH: phase_d = PH_DATA_LOW;
								PH_DATA_LOW:  phase_d = PH_POLL_LOW;
								default: begin
									// Poll until attention clears or the limit is hit
									if (attention_d) begin
										poll_count_d = poll_inc;
										if (poll_inc == '0 || poll_inc >= limit) begin
											done_d  = 1'b1;
											tmo_d   = 1'b1;
											phase_d = PH_IDLE;
										end
									end else if (phase_q == PH_POLL_HIGH) begin
										high_result_d = in_shift_d;
										poll_count_d  = '0;
										phase_d       = PH_POLL_LOW;
									end else begin
										done_d  = 1'b1;
										phase_d = PH_IDLE;
									end
								end
							endcase
						end
					end
				end
				default: ;
			endcase
		end
	end

	// Hold the sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			bit_index_q   <= '0;
			in_shift_q    <= '0;
			attention_q   <= 1'b0;
			is_read_q     <= 1'b0;
			high_result_q <= '0;
			poll_count_q  <= '0;
			poll_limit_q  <= POLL_LIMIT_RESET;
			out_valid_q   <= 1'b0;
		end else begin
			phase_q       <= phase_d;
			bit_index_q   <= bit_index_d;
			in_shift_q    <= in_shift_d;
			attention_q   <= attention_d;
			is_read_q     <= is_read_d;
			high_result_q <= high_result_d;
			poll_count_q  <= poll_count_d;
			if (cfg_valid && cfg_ready) begin
				poll_limit_q <= cfg_data;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Capture command words at issue
	always_ff @(posedge clk) begin
		if (load_words) begin
			opcode_q    <= item.opcode;
			addr_high_q <= item.addr_high;
			addr_low_q  <= item.addr_low;
			data_high_q <= item.data_high;
			data_low_q  <= item.data_low;
		end
	end

	// Capture the result transaction
	always_ff @(posedge clk) begin
		if (load_out) begin
			dsi_q       <= dsi_d;
			fend_q      <= fend_d;
			att_q       <= attention_d;
			done_q      <= done_d;
			tmo_q       <= tmo_d;
			resp_high_q <= high_result_d;
			resp_low_q  <= resp_low_d;
		end
	end

	assign out_valid     = out_valid_q;
	assign dsi_bit       = dsi_q;
	assign clock_pulse   = 1'b1;
	assign frame_end     = fend_q;
	assign attention     = att_q;
	assign command_done  = done_q;
	assign timed_out     = tmo_q;
	assign response_high = resp_high_q;
	assign response_low  = resp_low_q;

`ifndef ASSERT_OFF
	// A finished command leaves the sequencer idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && done_d) |=> (phase_q == PH_IDLE))
		else $error("command done but sequencer not idle");

	// The last bit of a frame restarts the bit counter
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(load_out && fend_d) |=> (bit_index_q == '0))
		else $error("bit counter not cleared after frame end");

	// An issue taken while idle starts with the opcode frame
	a_issue_start: assert property (@(posedge clk) disable iff (!arst_n)
		(load_words) |=> (phase_q == PH_OPCODE && bit_index_q == '0 && !out_valid_q ||
			phase_q == PH_OPCODE && bit_index_q == '0))
		else $error("issue did not start the opcode frame");

	// No result is produced while the output register is full and stalled
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !load_out)
		else $error("result loaded over a stalled result");
`endif

endmodule

// ===== rtl/bdm_serial_command_master_top.sv =====
`timescale 1ns / 1ps
// Background-debug serial master: front end, command queue and frame sequencer.
// Takes one item per clock while the queue has room; a tick result passes through the queue, then the output register.
// Issue items and ticks while idle produce no result; the sequencer runs one bit per tick.
// Throughput is set by the sequencer, which retires one queued item each cycle unless its output is full and stalled.
// Asynchronous reset: sequencer idle, queue empty, poll limit 1024.
module bdm_serial_command_master_top import bdm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [WORD_W-1:0] cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        command,
	input  logic [WORD_W-1:0] bdm_opcode,
	input  logic [WORD_W-1:0] addr_high,
	input  logic [WORD_W-1:0] addr_low,
	input  logic [WORD_W-1:0] data_high,
	input  logic [WORD_W-1:0] data_low,
	input  logic              dso_bit,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              dsi_bit,
	output logic              clock_pulse,
	output logic              frame_end,
	output logic              attention,
	output logic              command_done,
	output logic              timed_out,
	output logic [WORD_W-1:0] response_high,
	output logic [WORD_W-1:0] response_low
);

	push_t q_push;
	head_t q_head;
	logic  q_full;
	logic  q_pop;

	// Classify input transactions
	bdm_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.command    (command),
		.bdm_opcode (bdm_opcode),
		.addr_high  (addr_high),
		.addr_low   (addr_low),
		.data_high  (data_high),
		.data_low   (data_low),
		.dso_bit    (dso_bit),
		.q_full     (q_full),
		.q_push     (q_push)
	);

	// Decouple front and back
	bdm_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_push (q_push),
		.q_full (q_full),
		.q_pop  (q_pop),
		.q_head (q_head)
	);

	// Run the frame sequencer
	bdm_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.dsi_bit       (dsi_bit),
		.clock_pulse   (clock_pulse),
		.frame_end     (frame_end),
		.attention     (attention),
		.command_done  (command_done),
		.timed_out     (timed_out),
		.response_high (response_high),
		.response_low  (response_low)
	);

endmodule
